[src/cop_pkg.sv]
// ----------------------------------------------------------------------------
// cop_pkg
// Types, constants and fixed-point helpers for the centre of pressure block.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;
  localparam int NW        = 18;
  localparam int CW        = 51;
  localparam int DIV_BITS  = 32;

  localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  localparam logic [3:0] REG_NORMAL_X    = 4'd0;
  localparam logic [3:0] REG_NORMAL_Y    = 4'd1;
  localparam logic [3:0] REG_NORMAL_Z    = 4'd2;
  localparam logic [3:0] REG_POINT_X     = 4'd3;
  localparam logic [3:0] REG_POINT_Y     = 4'd4;
  localparam logic [3:0] REG_POINT_Z     = 4'd5;
  localparam logic [3:0] REG_MIN_FORCE   = 4'd6;
  localparam logic [3:0] REG_UNIT_TOL    = 4'd7;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FORCE_SMALL = 2'd1,
    ST_NOT_UNIT    = 2'd2
  } cop_status_t;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic signed [QW-1:0] px;
    logic signed [QW-1:0] py;
    logic signed [QW-1:0] pz;
    logic [30:0]          min_force;
    logic [15:0]          tol;
  } cop_cfg_t;

  typedef struct packed {
    logic signed [QW-1:0] fx;
    logic signed [QW-1:0] fy;
    logic signed [QW-1:0] fz;
    logic signed [QW-1:0] tx;
    logic signed [QW-1:0] ty;
    logic signed [QW-1:0] tz;
  } cop_wrench_t;

  typedef struct packed {
    cop_wrench_t w;
    cop_status_t status;
    logic [QW-1:0] den;
    logic [2:0]    neg;
    logic [2:0]    ovf;
  } cop_side_t;

  typedef struct packed {
    logic signed [QW-1:0] cop_x;
    logic signed [QW-1:0] cop_y;
    logic signed [QW-1:0] cop_z;
    logic signed [QW-1:0] normal_torque;
    cop_status_t          status;
  } cop_result_t;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] x);
    if (x > Q_MAX) begin
      return Q_MAX[QW-1:0];
    end
    if (x < Q_MIN) begin
      return Q_MIN[QW-1:0];
    end
    return x[QW-1:0];
  endfunction

  // Component of a - b x f from the two exact products of the cross term.
  function automatic logic signed [QW-1:0] cross_term(input logic signed [QW-1:0] a,
                                                      input logic signed [63:0] m0,
                                                      input logic signed [63:0] m1);
    return sat32(64'(a) - (rnd(m0) - rnd(m1)));
  endfunction

  function automatic logic signed [QW-1:0] dot3(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic signed [63:0] c);
    return sat32(rnd(a + b + c));
  endfunction

endpackage

[src/cop_ifs.sv]
// ----------------------------------------------------------------------------
// cop_ifs
// Channel interfaces: wrench samples in, results out, register writes.
// ----------------------------------------------------------------------------
interface cop_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] torque_x;
  logic signed [31:0] torque_y;
  logic signed [31:0] torque_z;
  modport source(output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                 input ready);
  modport sink(input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               output ready);
endinterface

interface cop_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cop_x;
  logic signed [31:0] cop_y;
  logic signed [31:0] cop_z;
  logic signed [31:0] normal_torque;
  logic [1:0]         status;
  modport source(output valid, cop_x, cop_y, cop_z, normal_torque, status, input ready);
  modport sink(input valid, cop_x, cop_y, cop_z, normal_torque, status, output ready);
endinterface

interface cop_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/cop_front.sv]
// ----------------------------------------------------------------------------
// cop_front
// Eight stages: torque moved to the plane point, normal part removed, cross
// product with the normal, and preparation of the signed division.
// ----------------------------------------------------------------------------
module cop_front (
  input  logic                          clk,
  input  logic                          rst,
  input  cop_pkg::cop_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cop_pkg::cop_wrench_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0][cop_pkg::CW-1:0]   out_mag,
  output cop_pkg::cop_side_t            out_side
);
  import cop_pkg::*;

  localparam int NS = 8;

  logic [NS:1] v;
  logic [NS:1] en;

  logic signed [NW-1:0] n [3];
  logic signed [QW-1:0] p [3];

  cop_wrench_t          w   [1:NS-1];
  logic signed [49:0]   nf1 [3];
  logic signed [63:0]   pf1 [6];
  logic signed [35:0]   nn1 [3];
  logic signed [QW-1:0] fn  [2:NS-1];
  logic                 notunit2;
  cop_status_t          status [3:NS-1];
  logic signed [QW-1:0] tp  [2:5][3];
  logic signed [49:0]   ntpp3 [3];
  logic signed [QW-1:0] ntp4;
  logic signed [49:0]   nq5 [3];
  logic signed [QW-1:0] tt6 [3];
  logic signed [49:0]   cp7 [6];

  logic signed [38:0]   sq;
  logic signed [38:0]   dev;
  logic signed [38:0]   adev;
  logic [QW-1:0]        afn2;
  logic signed [CW-1:0] c8 [3];
  logic [QW-1:0]        den8;

  assign n[0] = cfg.nx;
  assign n[1] = cfg.ny;
  assign n[2] = cfg.nz;
  assign p[0] = cfg.px;
  assign p[1] = cfg.py;
  assign p[2] = cfg.pz;

  assign en[NS] = !v[NS] || out_ready;
  genvar g;
  generate
    for (g = 1; g < NS; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate
  assign in_ready  = en[1];
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_comb begin
    sq   = 39'(nn1[0]) + 39'(nn1[1]) + 39'(nn1[2]);
    dev  = sq - (39'sd1 <<< (2 * FRAC_BITS));
    adev = dev[38] ? -dev : dev;
    afn2 = fn[2][QW-1] ? (~fn[2] + 32'd1) : fn[2];
    c8[0] = 51'(cp7[0]) - 51'(cp7[1]);
    c8[1] = 51'(cp7[2]) - 51'(cp7[3]);
    c8[2] = 51'(cp7[4]) - 51'(cp7[5]);
    den8  = fn[7][QW-1] ? (~fn[7] + 32'd1) : fn[7];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w[1]   <= in_data;
      nf1[0] <= n[0] * in_data.fx;
      nf1[1] <= n[1] * in_data.fy;
      nf1[2] <= n[2] * in_data.fz;
      pf1[0] <= p[1] * in_data.fz;
      pf1[1] <= p[2] * in_data.fy;
      pf1[2] <= p[2] * in_data.fx;
      pf1[3] <= p[0] * in_data.fz;
      pf1[4] <= p[0] * in_data.fy;
      pf1[5] <= p[1] * in_data.fx;
      for (int i = 0; i < 3; i++) begin
        nn1[i] <= n[i] * n[i];
      end
    end
    if (en[2]) begin
      w[2]     <= w[1];
      fn[2]    <= dot3(64'(nf1[0]), 64'(nf1[1]), 64'(nf1[2]));
      tp[2][0] <= cross_term(w[1].tx, pf1[0], pf1[1]);
      tp[2][1] <= cross_term(w[1].ty, pf1[2], pf1[3]);
      tp[2][2] <= cross_term(w[1].tz, pf1[4], pf1[5]);
      notunit2 <= adev > $signed(39'({cfg.tol, {FRAC_BITS{1'b0}}}));
    end
    if (en[3]) begin
      w[3]  <= w[2];
      fn[3] <= fn[2];
      tp[3] <= tp[2];
      for (int i = 0; i < 3; i++) begin
        ntpp3[i] <= n[i] * tp[2][i];
      end
      if (notunit2) begin
        status[3] <= ST_NOT_UNIT;
      end else if (afn2 <= {1'b0, cfg.min_force}) begin
        status[3] <= ST_FORCE_SMALL;
      end else begin
        status[3] <= ST_OK;
      end
    end
    if (en[4]) begin
      w[4]      <= w[3];
      fn[4]     <= fn[3];
      tp[4]     <= tp[3];
      status[4] <= status[3];
      ntp4      <= dot3(64'(ntpp3[0]), 64'(ntpp3[1]), 64'(ntpp3[2]));
    end
    if (en[5]) begin
      w[5]      <= w[4];
      fn[5]     <= fn[4];
      tp[5]     <= tp[4];
      status[5] <= status[4];
      for (int i = 0; i < 3; i++) begin
        nq5[i] <= n[i] * ntp4;
      end
    end
    if (en[6]) begin
      w[6]      <= w[5];
      fn[6]     <= fn[5];
      status[6] <= status[5];
      for (int i = 0; i < 3; i++) begin
        tt6[i] <= sat32(64'(tp[5][i]) - rnd(64'(nq5[i])));
      end
    end
    if (en[7]) begin
      w[7]      <= w[6];
      fn[7]     <= fn[6];
      status[7] <= status[6];
      cp7[0]    <= n[1] * tt6[2];
      cp7[1]    <= n[2] * tt6[1];
      cp7[2]    <= n[2] * tt6[0];
      cp7[3]    <= n[0] * tt6[2];
      cp7[4]    <= n[0] * tt6[1];
      cp7[5]    <= n[1] * tt6[0];
    end
    if (en[8]) begin
      out_side.w      <= w[7];
      out_side.status <= status[7];
      out_side.den    <= den8;
      for (int i = 0; i < 3; i++) begin
        out_mag[i]      <= c8[i][CW-1] ? CW'(-c8[i]) : CW'(c8[i]);
        out_side.neg[i] <= c8[i][CW-1] ^ fn[7][QW-1];
        out_side.ovf[i] <= {13'd0, (c8[i][CW-1] ? CW'(-c8[i]) : CW'(c8[i]))} >=
                           {den8, 32'd0};
      end
    end
  end

endmodule

[src/cop_div.sv]
// ----------------------------------------------------------------------------
// cop_div
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module cop_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0][cop_pkg::CW-1:0]      in_mag,
  input  cop_pkg::cop_side_t               in_side,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0][cop_pkg::DIV_BITS-1:0] out_quo,
  output cop_pkg::cop_side_t               out_side
);
  import cop_pkg::*;

  localparam int N = DIV_BITS;

  logic [N-1:0]          v;
  logic [N-1:0]          en;
  logic [CW-1:0]         rem  [N][3];
  logic [DIV_BITS-1:0]   quo  [N][3];
  cop_side_t             side [N];

  genvar st;
  generate
    for (st = 0; st < N; st++) begin : g_stage
      localparam int SH = N - 1 - st;
      logic [CW-1:0]       rp [3];
      logic [DIV_BITS-1:0] qp [3];
      cop_side_t           sp;
      logic                vp;
      logic [CW-1:0]       rn [3];
      logic [2:0]          qb;
      logic [63:0]         dsh;

      if (st == 0) begin : g_first
        assign vp = in_valid;
        assign sp = in_side;
        for (genvar l = 0; l < 3; l++) begin : g_l
          assign rp[l] = in_mag[l];
          assign qp[l] = '0;
        end
      end else begin : g_next
        assign vp = v[st-1];
        assign sp = side[st-1];
        for (genvar l = 0; l < 3; l++) begin : g_l
          assign rp[l] = rem[st-1][l];
          assign qp[l] = quo[st-1][l];
        end
      end

      if (st == N - 1) begin : g_last_en
        assign en[st] = !v[st] || out_ready;
      end else begin : g_mid_en
        assign en[st] = !v[st] || en[st+1];
      end

      always_comb begin
        dsh = 64'(sp.den) << SH;
        for (int l = 0; l < 3; l++) begin
          if (64'(rp[l]) >= dsh) begin
            rn[l] = rp[l] - dsh[CW-1:0];
            qb[l] = 1'b1;
          end else begin
            rn[l] = rp[l];
            qb[l] = 1'b0;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[st] <= 1'b0;
        end else if (en[st]) begin
          v[st] <= vp;
        end
      end

      always_ff @(posedge clk) begin
        if (en[st]) begin
          side[st] <= sp;
          for (int l = 0; l < 3; l++) begin
            rem[st][l] <= rn[l];
            quo[st][l] <= {qp[l][DIV_BITS-2:0], qb[l]};
          end
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[N-1];
  assign out_side  = side[N-1];
  assign out_quo[0] = quo[N-1][0];
  assign out_quo[1] = quo[N-1][1];
  assign out_quo[2] = quo[N-1][2];

endmodule

[src/cop_back.sv]
// ----------------------------------------------------------------------------
// cop_back
// Five stages: signed quotient plus plane point, torque moved to the centre
// of pressure, normal torque, and the result register.
// ----------------------------------------------------------------------------
module cop_back (
  input  logic                              clk,
  input  logic                              rst,
  input  cop_pkg::cop_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0][cop_pkg::DIV_BITS-1:0] in_quo,
  input  cop_pkg::cop_side_t                in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cop_pkg::cop_result_t              out_data
);
  import cop_pkg::*;

  localparam int NS = 5;

  logic [NS:1] v;
  logic [NS:1] en;

  logic signed [NW-1:0] n [3];
  logic signed [QW-1:0] p [3];
  logic signed [QW-1:0] qs [3];

  cop_wrench_t          w      [1:2];
  cop_status_t          status [1:NS-1];
  logic signed [QW-1:0] cop    [1:NS-1][3];
  logic signed [63:0]   cf2    [6];
  logic signed [QW-1:0] tc3    [3];
  logic signed [49:0]   ntp4   [3];

  assign n[0] = cfg.nx;
  assign n[1] = cfg.ny;
  assign n[2] = cfg.nz;
  assign p[0] = cfg.px;
  assign p[1] = cfg.py;
  assign p[2] = cfg.pz;

  assign en[NS] = !v[NS] || out_ready;
  genvar g;
  generate
    for (g = 1; g < NS; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate
  assign in_ready  = en[1];
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (in_side.ovf[l]) begin
        qs[l] = in_side.neg[l] ? Q_MIN[QW-1:0] : Q_MAX[QW-1:0];
      end else if (in_side.neg[l]) begin
        qs[l] = sat32(-$signed({32'd0, in_quo[l]}));
      end else begin
        qs[l] = sat32($signed({32'd0, in_quo[l]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w[1]      <= in_side.w;
      status[1] <= in_side.status;
      for (int l = 0; l < 3; l++) begin
        cop[1][l] <= sat32(64'(qs[l]) + 64'(p[l]));
      end
    end
    if (en[2]) begin
      w[2]      <= w[1];
      status[2] <= status[1];
      cop[2]    <= cop[1];
      cf2[0]    <= cop[1][1] * w[1].fz;
      cf2[1]    <= cop[1][2] * w[1].fy;
      cf2[2]    <= cop[1][2] * w[1].fx;
      cf2[3]    <= cop[1][0] * w[1].fz;
      cf2[4]    <= cop[1][0] * w[1].fy;
      cf2[5]    <= cop[1][1] * w[1].fx;
    end
    if (en[3]) begin
      status[3] <= status[2];
      cop[3]    <= cop[2];
      tc3[0]    <= cross_term(w[2].tx, cf2[0], cf2[1]);
      tc3[1]    <= cross_term(w[2].ty, cf2[2], cf2[3]);
      tc3[2]    <= cross_term(w[2].tz, cf2[4], cf2[5]);
    end
    if (en[4]) begin
      status[4] <= status[3];
      cop[4]    <= cop[3];
      for (int l = 0; l < 3; l++) begin
        ntp4[l] <= n[l] * tc3[l];
      end
    end
    if (en[5]) begin
      out_data.status <= status[4];
      if (status[4] == ST_OK) begin
        out_data.cop_x         <= cop[4][0];
        out_data.cop_y         <= cop[4][1];
        out_data.cop_z         <= cop[4][2];
        out_data.normal_torque <= dot3(64'(ntp4[0]), 64'(ntp4[1]), 64'(ntp4[2]));
      end else begin
        out_data.cop_x         <= '0;
        out_data.cop_y         <= '0;
        out_data.cop_z         <= '0;
        out_data.normal_torque <= '0;
      end
    end
  end

endmodule

[src/center_of_pressure_from_wrench.sv]
// ----------------------------------------------------------------------------
// center_of_pressure_from_wrench
// Centre of pressure and normal torque of a force/torque sample on a
// configured contact plane, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Role   Beat
// sample    sink   force_x/y/z, torque_x/y/z, signed Q16.16
// result    source cop_x/y/z, normal_torque (Q16.16), status
// cfg       sink   register index and write data
//
// One sample beat is taken in every cycle while not stalled; a result passes
// eight front stages, one stage per quotient bit of the 32-stage divider and
// five back stages. Reset clears all valid bits and loads the register reset
// values. A stalled result holds its stage and those behind it only as far as
// they are full; empty stages close up, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module center_of_pressure_from_wrench (
  input logic         clk,
  input logic         rst,
  cop_sample_if.sink  sample,
  cop_result_if.source result,
  cop_cfg_if.sink     cfg
);
  import cop_pkg::*;

  cop_cfg_t    cfg_q;
  cop_wrench_t in_w;

  logic                      f_valid;
  logic                      f_ready;
  logic [2:0][CW-1:0]        f_mag;
  cop_side_t                 f_side;
  logic                      d_valid;
  logic                      d_ready;
  logic [2:0][DIV_BITS-1:0]  d_quo;
  cop_side_t                 d_side;
  cop_result_t               res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.nx        <= '0;
      cfg_q.ny        <= '0;
      cfg_q.nz        <= NW'(1 << FRAC_BITS);
      cfg_q.px        <= '0;
      cfg_q.py        <= '0;
      cfg_q.pz        <= '0;
      cfg_q.min_force <= 31'd1;
      cfg_q.tol       <= 16'd8;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_NORMAL_X:  cfg_q.nx        <= cfg.data[NW-1:0];
        REG_NORMAL_Y:  cfg_q.ny        <= cfg.data[NW-1:0];
        REG_NORMAL_Z:  cfg_q.nz        <= cfg.data[NW-1:0];
        REG_POINT_X:   cfg_q.px        <= cfg.data;
        REG_POINT_Y:   cfg_q.py        <= cfg.data;
        REG_POINT_Z:   cfg_q.pz        <= cfg.data;
        REG_MIN_FORCE: cfg_q.min_force <= cfg.data[30:0];
        REG_UNIT_TOL:  cfg_q.tol       <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_w.fx = sample.force_x;
  assign in_w.fy = sample.force_y;
  assign in_w.fz = sample.force_z;
  assign in_w.tx = sample.torque_x;
  assign in_w.ty = sample.torque_y;
  assign in_w.tz = sample.torque_z;

  cop_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_data   (in_w),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_mag   (f_mag),
    .out_side  (f_side)
  );

  cop_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_mag    (f_mag),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  cop_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_quo    (d_quo),
    .in_side   (d_side),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res)
  );

  assign result.cop_x         = res.cop_x;
  assign result.cop_y         = res.cop_y;
  assign result.cop_z         = res.cop_z;
  assign result.normal_torque = res.normal_torque;
  assign result.status        = res.status;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |->
      result.cop_x == '0 && result.cop_y == '0 && result.cop_z == '0 &&
      result.normal_torque == '0)
    else $error("error result carries a nonzero position or torque");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample stalled although the result stage is empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid straight after reset");

endmodule
